// ----- rtl/core/lrpg_pkg.sv -----
// Shared types and constants for the line and rectangle pixel generator.
package lrpg_pkg;

    localparam int COLOR_BITS = 16;
    localparam int PANEL_BITS = 12;
    localparam int REQ_BITS   = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [REQ_BITS-1:0] REQ_POINT   = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_LINE    = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_RECT    = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_CPOINT  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_ADVANCE = 3'd4;

    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MIRROR_X     = 2'd1;
    localparam logic [1:0] REG_STROKE_COLOR = 2'd2;

    localparam logic [PANEL_BITS-1:0] PANEL_WIDTH_RESET  = 12'd800;
    localparam logic [COLOR_BITS-1:0] STROKE_COLOR_RESET = 16'h0505;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_LEFT   = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_RECT = 2'd2
    } job_mode_t;

    typedef enum logic [1:0] {
        DIR_HOLD  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd2
    } step_dir_t;

    typedef struct packed {
        logic [PANEL_BITS-1:0] panel_width;
        logic                  mirror_x;
        logic [COLOR_BITS-1:0] stroke_color;
    } cfg_t;

endpackage

// ----- rtl/core/lrpg_apb_regs.sv -----
// APB configuration registers: panel width, mirror mode and stroke color.
module lrpg_apb_regs
    import lrpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= PANEL_WIDTH_RESET;
            cfg_reg.mirror_x     <= 1'b0;
            cfg_reg.stroke_color <= STROKE_COLOR_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PANEL_WIDTH:  cfg_reg.panel_width  <= pwdata[PANEL_BITS-1:0];
                REG_MIRROR_X:     cfg_reg.mirror_x     <= pwdata[0];
                REG_STROKE_COLOR: cfg_reg.stroke_color <= pwdata[COLOR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PANEL_WIDTH:  prdata = {{(APB_DATA_BITS-PANEL_BITS){1'b0}}, cfg_reg.panel_width};
            REG_MIRROR_X:     prdata = {{(APB_DATA_BITS-1){1'b0}}, cfg_reg.mirror_x};
            REG_STROKE_COLOR: prdata = {{(APB_DATA_BITS-COLOR_BITS){1'b0}}, cfg_reg.stroke_color};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/lrpg_in_stage.sv -----
// Input register that holds one request item until the draw core takes it.
module lrpg_in_stage
    import lrpg_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [REQ_BITS-1:0]   req_type,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0] fill_color,
    input  logic                  take,
    output logic                  item_valid,
    output logic [REQ_BITS-1:0]   item_req,
    output logic [COORD_BITS-1:0] item_sx,
    output logic [COORD_BITS-1:0] item_sy,
    output logic [COORD_BITS-1:0] item_ex,
    output logic [COORD_BITS-1:0] item_ey,
    output logic [COLOR_BITS-1:0] item_fc
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  accept;
    logic [REQ_BITS-1:0]   req_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] ex_reg;
    logic [COORD_BITS-1:0] ey_reg;
    logic [COLOR_BITS-1:0] fc_reg;

    assign in_stall = valid_reg & ~take;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            sx_reg  <= start_x;
            sy_reg  <= start_y;
            ex_reg  <= end_x;
            ey_reg  <= end_y;
            fc_reg  <= fill_color;
        end
    end

    assign item_valid = valid_reg;
    assign item_req   = req_reg;
    assign item_sx    = sx_reg;
    assign item_sy    = sy_reg;
    assign item_ex    = ex_reg;
    assign item_ey    = ey_reg;
    assign item_fc    = fc_reg;

endmodule

// ----- rtl/core/lrpg_draw_core.sv -----
// Draw state and one-step DDA line walker that turns each item into at most one pixel.
module lrpg_draw_core
    import lrpg_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  fire,
    input  logic [REQ_BITS-1:0]   item_req,
    input  logic [COORD_BITS-1:0] item_sx,
    input  logic [COORD_BITS-1:0] item_sy,
    input  logic [COORD_BITS-1:0] item_ex,
    input  logic [COORD_BITS-1:0] item_ey,
    input  logic [COLOR_BITS-1:0] item_fc,
    output logic                  res_valid,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic [COLOR_BITS-1:0] res_color,
    output logic                  res_final
);

    localparam int CB = COORD_BITS;

    job_mode_t       mode_reg, mode_next;
    logic [1:0]      side_reg, side_next;
    logic [CB-1:0]   cur_x_reg, cur_x_next;
    logic [CB-1:0]   cur_y_reg, cur_y_next;
    logic [CB-1:0]   dx_reg, dx_next;
    logic [CB-1:0]   dy_reg, dy_next;
    step_dir_t       dir_x_reg, dir_x_next;
    step_dir_t       dir_y_reg, dir_y_next;
    logic [CB:0]     err_x_reg, err_x_next;
    logic [CB:0]     err_y_reg, err_y_next;
    logic [CB-1:0]   major_reg, major_next;
    logic [CB:0]     left_reg, left_next;
    logic [CB-1:0]   corners_reg [4];
    logic [CB-1:0]   corners_next [4];

    logic [1:0]      side_inc;
    logic [CB-1:0]   su_ax, su_ay, su_bx, su_by;
    logic [CB-1:0]   su_dx, su_dy, su_major;
    step_dir_t       su_dir_x, su_dir_y;

    logic [CB:0]     sum_x, sum_y;
    logic [CB-1:0]   walk_x, walk_y;
    logic [CB:0]     walk_err_x, walk_err_y;
    logic [CB:0]     left_dec;

    function automatic logic [CB-1:0] mirror_fn(input cfg_t c, input logic [CB-1:0] x);
        logic [CB+PANEL_BITS-1:0] pw_ext;
        pw_ext = {{CB{1'b0}}, c.panel_width};
        if (c.mirror_x)
            mirror_fn = pw_ext[CB-1:0] - CB'(1) - x;
        else
            mirror_fn = x;
    endfunction

    function automatic logic [CB-1:0] move_fn(input logic [CB-1:0] c, input step_dir_t d);
        unique case (d)
            DIR_PLUS:  move_fn = c + CB'(1);
            DIR_MINUS: move_fn = c - CB'(1);
            default:   move_fn = c;
        endcase
    endfunction

    assign side_inc = side_reg + 2'd1;

    always_comb
    begin
        priority if (item_req == REQ_ADVANCE)
        begin
            unique case (side_inc)
                SIDE_LEFT:
                begin
                    su_ax = corners_reg[0]; su_ay = corners_reg[1];
                    su_bx = corners_reg[0]; su_by = corners_reg[3];
                end
                SIDE_BOTTOM:
                begin
                    su_ax = corners_reg[0]; su_ay = corners_reg[3];
                    su_bx = corners_reg[2]; su_by = corners_reg[3];
                end
                SIDE_RIGHT:
                begin
                    su_ax = corners_reg[2]; su_ay = corners_reg[1];
                    su_bx = corners_reg[2]; su_by = corners_reg[3];
                end
                default:
                begin
                    su_ax = corners_reg[0]; su_ay = corners_reg[1];
                    su_bx = corners_reg[2]; su_by = corners_reg[1];
                end
            endcase
        end
        else if (item_req == REQ_RECT)
        begin
            su_ax = item_sx; su_ay = item_sy;
            su_bx = item_ex; su_by = item_sy;
        end
        else
        begin
            su_ax = item_sx; su_ay = item_sy;
            su_bx = item_ex; su_by = item_ey;
        end
    end

    always_comb
    begin
        priority if (su_bx > su_ax)
        begin
            su_dx = su_bx - su_ax; su_dir_x = DIR_PLUS;
        end
        else if (su_bx < su_ax)
        begin
            su_dx = su_ax - su_bx; su_dir_x = DIR_MINUS;
        end
        else
        begin
            su_dx = '0; su_dir_x = DIR_HOLD;
        end
        priority if (su_by > su_ay)
        begin
            su_dy = su_by - su_ay; su_dir_y = DIR_PLUS;
        end
        else if (su_by < su_ay)
        begin
            su_dy = su_ay - su_by; su_dir_y = DIR_MINUS;
        end
        else
        begin
            su_dy = '0; su_dir_y = DIR_HOLD;
        end
        su_major = (su_dx > su_dy) ? su_dx : su_dy;
    end

    always_comb
    begin
        sum_x    = err_x_reg + {1'b0, dx_reg};
        sum_y    = err_y_reg + {1'b0, dy_reg};
        left_dec = left_reg - (CB+1)'(1);
        if (sum_x > {1'b0, major_reg})
        begin
            walk_err_x = sum_x - {1'b0, major_reg};
            walk_x     = move_fn(cur_x_reg, dir_x_reg);
        end
        else
        begin
            walk_err_x = sum_x;
            walk_x     = cur_x_reg;
        end
        if (sum_y > {1'b0, major_reg})
        begin
            walk_err_y = sum_y - {1'b0, major_reg};
            walk_y     = move_fn(cur_y_reg, dir_y_reg);
        end
        else
        begin
            walk_err_y = sum_y;
            walk_y     = cur_y_reg;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        side_next  = side_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dir_x_next = dir_x_reg;
        dir_y_next = dir_y_reg;
        err_x_next = err_x_reg;
        err_y_next = err_y_reg;
        major_next = major_reg;
        left_next  = left_reg;
        for (int i = 0; i < 4; i++)
            corners_next[i] = corners_reg[i];
        res_valid = 1'b0;
        res_x     = mirror_fn(cfg, item_sx);
        res_y     = item_sy;
        res_color = cfg.stroke_color;
        res_final = 1'b0;

        unique case (item_req)
            REQ_POINT:
            begin
                mode_next = MODE_IDLE;
                res_valid = 1'b1;
                res_final = 1'b1;
            end
            REQ_CPOINT:
            begin
                mode_next = MODE_IDLE;
                res_valid = 1'b1;
                res_x     = item_sx;
                res_color = item_fc;
                res_final = 1'b1;
            end
            REQ_LINE, REQ_RECT, REQ_ADVANCE:
            begin
                if (item_req != REQ_ADVANCE || (mode_reg != MODE_IDLE && left_reg == '0))
                begin
                    if (item_req == REQ_ADVANCE)
                        side_next = side_inc;
                    else
                        side_next = SIDE_TOP;
                    if (item_req == REQ_LINE)
                        mode_next = MODE_LINE;
                    if (item_req == REQ_RECT)
                    begin
                        mode_next       = MODE_RECT;
                        corners_next[0] = item_sx;
                        corners_next[1] = item_sy;
                        corners_next[2] = item_ex;
                        corners_next[3] = item_ey;
                    end
                    cur_x_next = su_ax;
                    cur_y_next = su_ay;
                    dx_next    = su_dx;
                    dy_next    = su_dy;
                    dir_x_next = su_dir_x;
                    dir_y_next = su_dir_y;
                    err_x_next = '0;
                    err_y_next = '0;
                    major_next = su_major;
                    left_next  = {1'b0, su_major} + (CB+1)'(1);
                    res_valid  = 1'b1;
                    res_x      = mirror_fn(cfg, su_ax);
                    res_y      = su_ay;
                end
                else if (mode_reg != MODE_IDLE)
                begin
                    cur_x_next = walk_x;
                    cur_y_next = walk_y;
                    err_x_next = walk_err_x;
                    err_y_next = walk_err_y;
                    left_next  = left_dec;
                    res_valid  = 1'b1;
                    res_x      = mirror_fn(cfg, walk_x);
                    res_y      = walk_y;
                    if (left_dec == '0 && (mode_reg == MODE_LINE || side_reg == SIDE_RIGHT))
                    begin
                        res_final = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            side_reg  <= SIDE_TOP;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            dir_x_reg <= DIR_HOLD;
            dir_y_reg <= DIR_HOLD;
            err_x_reg <= '0;
            err_y_reg <= '0;
            major_reg <= '0;
            left_reg  <= '0;
            for (int i = 0; i < 4; i++)
                corners_reg[i] <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            side_reg  <= side_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dir_x_reg <= dir_x_next;
            dir_y_reg <= dir_y_next;
            err_x_reg <= err_x_next;
            err_y_reg <= err_y_next;
            major_reg <= major_next;
            left_reg  <= left_next;
            for (int i = 0; i < 4; i++)
                corners_reg[i] <= corners_next[i];
        end
    end

endmodule

// ----- rtl/core/lrpg_out_stage.sv -----
// Result register that holds one pixel item until the sink takes it.
module lrpg_out_stage
    import lrpg_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  res_valid,
    input  logic [COORD_BITS-1:0] res_x,
    input  logic [COORD_BITS-1:0] res_y,
    input  logic [COLOR_BITS-1:0] res_color,
    input  logic                  res_final,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0] pixel_color,
    output logic                  final_pixel
);

    logic                  valid_reg;
    logic                  load_data;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  final_reg;

    assign can_load  = ~valid_reg | ~out_stall;
    assign load_data = fire & res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load_data;
    end

    always_ff @(posedge clk)
    begin
        if (load_data)
        begin
            x_reg     <= res_x;
            y_reg     <= res_y;
            color_reg <= res_color;
            final_reg <= res_final;
        end
    end

    assign out_valid   = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_color = color_reg;
    assign final_pixel = final_reg;

endmodule

// ----- rtl/core/line_rect_pixel_generator.sv -----
// Top level of the point, line and rectangle pixel generator.
// The block takes one item per clock while the output is not stalled and gives at most
// one pixel per item, so a line of distance d costs one command item and d+1 advance items.
// An item passes an input register and then a result register before its pixel is offered
// at the output; the rate is set by the single add, compare and subtract per axis of the
// line walker between those registers. Advance items while idle and unused request codes
// give no pixel. Configuration is written over APB at byte addresses 0, 4 and 8; the user
// must see that it is changed only while no item is in flight, as the block does not enforce it.
module line_rect_pixel_generator
    import lrpg_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [REQ_BITS-1:0]      req_type,
    input  logic [COORD_BITS-1:0]    start_x,
    input  logic [COORD_BITS-1:0]    start_y,
    input  logic [COORD_BITS-1:0]    end_x,
    input  logic [COORD_BITS-1:0]    end_y,
    input  logic [COLOR_BITS-1:0]    fill_color,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [COORD_BITS-1:0]    pixel_x,
    output logic [COORD_BITS-1:0]    pixel_y,
    output logic [COLOR_BITS-1:0]    pixel_color,
    output logic                     final_pixel
);

    cfg_t                  cfg;
    logic                  can_load;
    logic                  fire;
    logic                  item_valid;
    logic [REQ_BITS-1:0]   item_req;
    logic [COORD_BITS-1:0] item_sx;
    logic [COORD_BITS-1:0] item_sy;
    logic [COORD_BITS-1:0] item_ex;
    logic [COORD_BITS-1:0] item_ey;
    logic [COLOR_BITS-1:0] item_fc;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic [COLOR_BITS-1:0] res_color;
    logic                  res_final;

    assign fire = item_valid & can_load;

    lrpg_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrpg_in_stage #(.COORD_BITS(COORD_BITS)) u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .fill_color (fill_color),
        .take       (can_load),
        .item_valid (item_valid),
        .item_req   (item_req),
        .item_sx    (item_sx),
        .item_sy    (item_sy),
        .item_ex    (item_ex),
        .item_ey    (item_ey),
        .item_fc    (item_fc)
    );

    lrpg_draw_core #(.COORD_BITS(COORD_BITS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .item_req  (item_req),
        .item_sx   (item_sx),
        .item_sy   (item_sy),
        .item_ex   (item_ex),
        .item_ey   (item_ey),
        .item_fc   (item_fc),
        .res_valid (res_valid),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_color (res_color),
        .res_final (res_final)
    );

    lrpg_out_stage #(.COORD_BITS(COORD_BITS)) u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_color   (res_color),
        .res_final   (res_final),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .final_pixel (final_pixel)
    );

endmodule
